[rtl/core/block_hash_queue_table_top_assert.svh]
// Assertion macros shared by the hash queue table RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef BLOCK_HASH_QUEUE_TABLE_TOP_ASSERT_SVH
`define BLOCK_HASH_QUEUE_TABLE_TOP_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define BQT_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that implies another one in the same cycle.
`define BQT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

[rtl/core/bqt_pkg.sv]
// Shared types and codes of the hash queue table.
// Depends on nothing; used by bqt_cell and the top level of the block.
package bqt_pkg;

  localparam logic [1:0] ACT_SEARCH = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_DELETE = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;

  // Width of the block number field on the request channel.
  localparam int BlockNumW = 16;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] block_number;
  } req_t;

  typedef struct packed {
    logic       found;
    logic [2:0] position;
    logic [1:0] status;
  } rsp_t;

  // Flags of the token that walks the cell chain.
  typedef struct packed {
    logic valid;
    logic shift;
  } tok_flags_t;

  // What a cell reports to the controller when the token ends or hits there.
  typedef struct packed {
    logic hit;
    logic miss;
    logic del_done;
  } cell_stat_t;

endpackage

[rtl/core/bqt_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module bqt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/bqt_hash.sv]
// Bucket index unit: key modulo the bucket count, by a reciprocal
// multiply for the quotient, then a multiply back and a subtract.
// Depends on nothing.
module bqt_hash #(
  parameter int NUM_BUCKETS = 4,
  parameter int KEY_W = 16,
  localparam int RW = $clog2(NUM_BUCKETS)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [KEY_W-1:0] key,
  output logic             last,
  output logic [RW-1:0]    bucket
);

  // With the shift at KEY_W plus ceil(log2 NUM_BUCKETS) and the reciprocal
  // rounded up, the shifted product is the exact quotient for every key.
  localparam int     SH    = KEY_W + RW;
  localparam longint RECIP = ((longint'(1) << SH) + longint'(NUM_BUCKETS) - longint'(1))
                             / longint'(NUM_BUCKETS);
  localparam int     PW    = 2 * KEY_W + 1;

  logic [KEY_W-1:0] kreg;
  logic [KEY_W-1:0] quot;
  logic [PW-1:0]    prod;
  logic [KEY_W-1:0] back;
  logic [1:0]       cnt;
  logic [RW-1:0]    rem;

  assign prod = PW'(kreg) * PW'(RECIP);
  assign back = quot * KEY_W'(NUM_BUCKETS);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= 2'd2;
    end else if (cnt != '0) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      kreg <= key;
    end
    if (cnt == 2'd2) begin
      quot <= KEY_W'(prod >> SH);
    end
    if (cnt == 2'd1) begin
      rem <= RW'(kreg - back);
    end
  end

  assign last   = (cnt == 2'd1);
  assign bucket = rem;

endmodule

[rtl/core/bqt_cell.sv]
// One slot position of every bucket, plus the token stage of the chain.
// Depends on bqt_pkg and bqt_ram.
module bqt_cell #(
  parameter int KEY_W = 16,
  parameter int NUM_BUCKETS = 4,
  parameter int CNT_W = 4,
  parameter int POS_W = 3,
  localparam int RW = $clog2(NUM_BUCKETS)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [RW-1:0]       addr,
  input  logic [KEY_W-1:0]    key,
  input  logic                del_op,
  input  logic                load,
  input  bqt_pkg::tok_flags_t tok_in,
  input  logic [CNT_W-1:0]    left_in,
  input  logic [POS_W-1:0]    pos_in,
  output bqt_pkg::tok_flags_t tok_out,
  output logic [CNT_W-1:0]    left_out,
  output logic [POS_W-1:0]    pos_out,
  input  logic [KEY_W-1:0]    rd_next,
  output logic [KEY_W-1:0]    rd,
  output bqt_pkg::cell_stat_t stat,
  output logic [POS_W-1:0]    hit_pos
);

  bqt_pkg::tok_flags_t tok;
  logic [CNT_W-1:0]    left;
  logic [POS_W-1:0]    pos;
  logic                live;
  logic                more;
  logic                match;
  logic                moving;
  logic                we;
  logic [KEY_W-1:0]    wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= '0;
    end else begin
      tok <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    left <= left_in;
    pos  <= pos_in;
  end

  // The token's left field counts the live entries from this slot upward.
  assign live   = (left != '0);
  assign more   = (left > CNT_W'(1));
  assign match  = tok.valid && !tok.shift && live && (rd == key);
  assign moving = tok.valid && (tok.shift || (match && del_op));

  assign stat.hit      = match;
  assign stat.miss     = tok.valid && !tok.shift && (!live || (!match && !more));
  assign stat.del_done = moving && !more;

  assign tok_out.valid = more && ((tok.valid && !tok.shift && !match) || moving);
  assign tok_out.shift = moving;
  assign left_out      = left - CNT_W'(1);
  assign pos_out       = pos + POS_W'(1);
  assign hit_pos       = pos;

  // A delete closes the gap by taking the upper neighbor's entry.
  assign we    = load || (moving && more);
  assign wdata = load ? key : rd_next;

  bqt_ram #(
    .WIDTH(KEY_W),
    .DEPTH(NUM_BUCKETS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (addr),
    .wdata (wdata),
    .raddr (addr),
    .rdata (rd)
  );

endmodule

[rtl/core/block_hash_queue_table_top.sv]
// Top level of the hash queue table: controller, bucket counts and cell chain.
// Depends on bqt_pkg, bqt_ram, bqt_hash, bqt_cell and the assertion header.
//
//   Channel | Beat carries              | Handshake
//   --------+---------------------------+----------------------------
//   req     | action, block_number      | req_valid / req_stall (out)
//   rsp     | found, position, status   | rsp_valid / rsp_stall (in)
//
// One request is in flight at a time. Each request passes S_HASH, S_READ
// and S_LAUNCH, and for a search or delete then S_SCAN, before S_DONE loads
// the response register; an insert, a no-op or a full bucket skips S_SCAN.
// The hash unit does a reciprocal multiply, then a multiply back and a
// subtract. In S_SCAN the token moves one cell a cycle, over at least one cell
// and at most the bucket's entry count, or one cell if the bucket is empty.
// After reset the bucket counts are cleared in S_CLEAR, during which req_stall
// stays high. A stalled response waits in its register while the next request
// is already taken and worked on.
`include "block_hash_queue_table_top_assert.svh"

module block_hash_queue_table_top #(
  parameter int NUM_BUCKETS = 4,
  parameter int ENTRIES_PER_BUCKET = 8,
  parameter int BLOCK_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  bqt_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output bqt_pkg::rsp_t rsp
);

  // Only the low BLOCK_BITS of the block number take part, and the request
  // field holds no more than its own width.
  localparam int KEY_W = (BLOCK_BITS < bqt_pkg::BlockNumW) ? BLOCK_BITS : bqt_pkg::BlockNumW;
  localparam int RW    = $clog2(NUM_BUCKETS);
  localparam int CNT_W = $clog2(ENTRIES_PER_BUCKET + 1);
  localparam int POS_W = $clog2(ENTRIES_PER_BUCKET);
  localparam int E     = ENTRIES_PER_BUCKET;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_HASH   = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_LAUNCH = 3'd4;
  localparam logic [2:0] S_SCAN   = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [1:0]       act;
  logic [KEY_W-1:0] key;
  logic [RW-1:0]    clr_addr;
  logic             res_found;
  logic [POS_W-1:0] res_pos;
  logic [1:0]       res_status;

  logic             accept;
  logic             rsp_free;
  logic             hash_last;
  logic [RW-1:0]    bucket;
  logic [CNT_W-1:0] cnt_rd;
  logic             cnt_we;
  logic [RW-1:0]    cnt_waddr;
  logic [CNT_W-1:0] cnt_wdata;
  logic             full;
  logic             ins_go;
  logic             launch;
  logic             del_op;

  bqt_pkg::tok_flags_t tok0;
  bqt_pkg::tok_flags_t fl_c   [E];
  logic [CNT_W-1:0]    left_c [E];
  logic [POS_W-1:0]    pos_c  [E];
  logic [KEY_W-1:0]    rd_c   [E];
  bqt_pkg::cell_stat_t stat_c [E];
  logic [POS_W-1:0]    hpos_c [E];
  logic [E-1:0]        load;
  logic [E-1:0]        cell_act;
  logic                any_hit;
  logic                any_miss;
  logic                any_del;
  logic [POS_W-1:0]    hpos;

  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != S_IDLE);
  assign rsp_free  = !rsp_valid || !rsp_stall;

  // The bucket index is worked out right after the request beat.
  bqt_hash #(
    .NUM_BUCKETS(NUM_BUCKETS),
    .KEY_W(KEY_W)
  ) u_hash (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .key    (req.block_number[KEY_W-1:0]),
    .last   (hash_last),
    .bucket (bucket)
  );

  // Entry count of each bucket. It is read during S_READ so that it is
  // valid from S_LAUNCH on, and written back only by an insert that fits or a delete that ends.
  assign full      = (cnt_rd >= CNT_W'(E));
  assign ins_go    = (state == S_LAUNCH) && (act == bqt_pkg::ACT_INSERT) && !full;
  assign launch    = (state == S_LAUNCH) &&
                     ((act == bqt_pkg::ACT_SEARCH) || (act == bqt_pkg::ACT_DELETE));
  assign del_op    = (act == bqt_pkg::ACT_DELETE);
  assign cnt_we    = (state == S_CLEAR) || ins_go || ((state == S_SCAN) && any_del);
  assign cnt_waddr = (state == S_CLEAR) ? clr_addr : bucket;
  assign cnt_wdata = (state == S_CLEAR) ? '0 :
                     ins_go             ? cnt_rd + CNT_W'(1) : cnt_rd - CNT_W'(1);

  bqt_ram #(
    .WIDTH(CNT_W),
    .DEPTH(NUM_BUCKETS)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (bucket),
    .rdata (cnt_rd)
  );

  // The token enters the first cell carrying the bucket's live entry count.
  assign tok0.valid = launch;
  assign tok0.shift = 1'b0;

  for (genvar k = 0; k < E; k++) begin : g_cell
    bqt_pkg::tok_flags_t fl_in;
    logic [CNT_W-1:0]    left_in;
    logic [POS_W-1:0]    pos_in;
    logic [KEY_W-1:0]    nxt;

    if (k == 0) begin : g_head
      assign fl_in   = tok0;
      assign left_in = cnt_rd;
      assign pos_in  = '0;
    end else begin : g_link
      assign fl_in   = fl_c[k-1];
      assign left_in = left_c[k-1];
      assign pos_in  = pos_c[k-1];
    end

    if (k == E - 1) begin : g_tail
      assign nxt = rd_c[k];
    end else begin : g_mid
      assign nxt = rd_c[k+1];
    end

    // An insert writes the slot just above the bucket's current tail.
    assign load[k] = ins_go && (cnt_rd == CNT_W'(k));

    bqt_cell #(
      .KEY_W(KEY_W),
      .NUM_BUCKETS(NUM_BUCKETS),
      .CNT_W(CNT_W),
      .POS_W(POS_W)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .addr     (bucket),
      .key      (key),
      .del_op   (del_op),
      .load     (load[k]),
      .tok_in   (fl_in),
      .left_in  (left_in),
      .pos_in   (pos_in),
      .tok_out  (fl_c[k]),
      .left_out (left_c[k]),
      .pos_out  (pos_c[k]),
      .rd_next  (nxt),
      .rd       (rd_c[k]),
      .stat     (stat_c[k]),
      .hit_pos  (hpos_c[k])
    );
  end

  // Only the cell holding the token reports, so the reports are simply ORed.
  always_comb begin
    any_hit  = 1'b0;
    any_miss = 1'b0;
    any_del  = 1'b0;
    hpos     = '0;
    for (int k = 0; k < E; k++) begin
      any_hit     = any_hit | stat_c[k].hit;
      any_miss    = any_miss | stat_c[k].miss;
      any_del     = any_del | stat_c[k].del_done;
      cell_act[k] = stat_c[k].hit | stat_c[k].miss | stat_c[k].del_done;
      if (stat_c[k].hit) begin
        hpos = hpos | hpos_c[k];
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == RW'(NUM_BUCKETS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        if (hash_last) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_LAUNCH;
      end
      S_LAUNCH: begin
        state_next = launch ? S_SCAN : S_DONE;
      end
      S_SCAN: begin
        // A search ends on its first report; a delete runs on until the
        // entries above the hit have moved down, or until it misses.
        if (any_miss || (!del_op && any_hit) || (del_op && any_del)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + RW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act <= req.action;
      key <= req.block_number[KEY_W-1:0];
    end
    if (state == S_LAUNCH) begin
      res_found  <= 1'b0;
      res_pos    <= ins_go ? cnt_rd[POS_W-1:0] : '0;
      res_status <= ((act == bqt_pkg::ACT_INSERT) && full) ? bqt_pkg::ST_FULL : bqt_pkg::ST_OK;
    end else if (state == S_SCAN) begin
      if (any_hit) begin
        res_found <= 1'b1;
        res_pos   <= hpos;
      end
      if (any_miss) begin
        res_status <= bqt_pkg::ST_MISSING;
      end
    end
  end

  // The response register lets the next request start while this beat waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == S_DONE) && rsp_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && rsp_free) begin
      rsp.found    <= res_found;
      rsp.position <= 3'(res_pos);
      rsp.status   <= res_status;
    end
  end

  `BQT_ASSERT_ALWAYS(a_single_token, clk, rst, $onehot0(cell_act), "two cells reported at once")
  `BQT_ASSERT_IMPLY(a_no_load_full, clk, rst, (state == S_LAUNCH) && full, load == '0, "insert into a full bucket")
  `BQT_ASSERT_IMPLY(a_del_after_hit, clk, rst, any_del, any_hit || res_found, "shift ended without a hit")

endmodule

[dv/hash_table_checker.sv]
// Checker for the hash queue table: watches both channels and predicts each response.
// Depends on bqt_pkg for the request and response beat types and the action and status codes.
module hash_table_checker #(
  parameter int NUM_BUCKETS = 4,
  parameter int ENTRIES_PER_BUCKET = 8,
  parameter int BLOCK_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_stall,
  input  bqt_pkg::req_t req,
  input  logic          rsp_valid,
  input  logic          rsp_stall,
  input  bqt_pkg::rsp_t rsp,
  output int            mismatches,
  output int            outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [BLOCK_BITS-1:0] bucket_keys [NUM_BUCKETS][ENTRIES_PER_BUCKET];
  int                    bucket_fill [NUM_BUCKETS];
  bqt_pkg::rsp_t         awaited_rsp_q [$];
  int                    rsp_index = 0;

  initial mismatches = 0;
  initial outstanding = 0;

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("checker: response %0d field %s is %0d, predicted %0d",
             rsp_index, field, got, want);
    mismatches++;
  endtask

  // Applies one request to the shadow table and returns the response it must produce.
  function automatic bqt_pkg::rsp_t table_lookup_update(input bqt_pkg::req_t beat);
    bqt_pkg::rsp_t         answer;
    logic [BLOCK_BITS-1:0] key;
    int                    bucket;
    int                    hit;
    answer = '0;
    answer.status = bqt_pkg::ST_OK;
    key = beat.block_number[BLOCK_BITS-1:0];
    bucket = int'(key % NUM_BUCKETS);
    hit = -1;
    for (int k = 0; k < bucket_fill[bucket]; k++) begin
      if (hit < 0 && bucket_keys[bucket][k] == key) hit = k;
    end
    case (beat.action)
      bqt_pkg::ACT_SEARCH: begin
        if (hit >= 0) begin
          answer.found = 1'b1;
          answer.position = 3'(hit);
        end else begin
          answer.status = bqt_pkg::ST_MISSING;
        end
      end
      bqt_pkg::ACT_INSERT: begin
        if (bucket_fill[bucket] >= ENTRIES_PER_BUCKET) begin
          answer.status = bqt_pkg::ST_FULL;
        end else begin
          bucket_keys[bucket][bucket_fill[bucket]] = key;
          answer.position = 3'(bucket_fill[bucket]);
          bucket_fill[bucket]++;
        end
      end
      bqt_pkg::ACT_DELETE: begin
        if (hit >= 0) begin
          // Later entries move down one slot so the bucket keeps its order.
          for (int k = hit; k + 1 < bucket_fill[bucket]; k++) begin
            bucket_keys[bucket][k] = bucket_keys[bucket][k + 1];
          end
          bucket_fill[bucket]--;
          answer.found = 1'b1;
          answer.position = 3'(hit);
        end else begin
          answer.status = bqt_pkg::ST_MISSING;
        end
      end
      default: begin
      end
    endcase
    return answer;
  endfunction

  always @(posedge clk) begin
    bqt_pkg::rsp_t want;
    if (rst) begin
      foreach (bucket_fill[b]) bucket_fill[b] = 0;
      awaited_rsp_q.delete();
    end else begin
      if (req_valid && !req_stall) awaited_rsp_q.push_back(table_lookup_update(req));
      if (rsp_valid && !rsp_stall) begin
        if (awaited_rsp_q.size() == 0) begin
          // A beat with no request waiting counts as one unexpected response.
          report_mismatch("unexpected", 1, 0);
        end else begin
          want = awaited_rsp_q.pop_front();
          if (rsp.found !== want.found) report_mismatch("found", rsp.found, want.found);
          if (rsp.position !== want.position)
            report_mismatch("position", rsp.position, want.position);
          if (rsp.status !== want.status) report_mismatch("status", rsp.status, want.status);
        end
        rsp_index++;
      end
    end
    outstanding = awaited_rsp_q.size();
  end

endmodule

[dv/testbench.sv]
// Top of the hash queue table testbench: clock, reset, request stimulus and response stall.
// Depends on bqt_pkg, block_hash_queue_table_top and hash_table_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_BUCKETS = 4;
  localparam int ENTRIES_PER_BUCKET = 8;
  localparam int BLOCK_BITS = 16;

  // The action encoding leaves one code unused; the block treats it as a no-op.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // Cycles without any accepted beat on either channel before the run is abandoned.
  // The slowest legal stretch is the deliberate response hold-off below, plus a
  // search walking a full bucket while the receiver stalls.
  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  // Margin at the end of the run, beyond the longest request-to-response latency.
  localparam int DRAIN_CYCLES = 40;
  localparam int POOL_SIZE = 24;
  localparam int PHASE_COUNT = 6;
  localparam int BEATS_PER_PHASE = 238;

  logic clk;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  bqt_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  bqt_pkg::rsp_t rsp;

  int mismatches;
  int outstanding;

  // Idle and stall rates in percent, changed by the stimulus from phase to phase.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // The stimulus bumps hold_orders to ask for a long response hold-off; the stall
  // process notices the change and counts the hold-off down on its own.
  int hold_orders = 0;
  int hold_taken = 0;
  int hold_left = 0;

  int quiet_cycles = 0;

  // A small pool of keys, spread over all buckets, so that random traffic keeps
  // hitting the same entries: searches find them, duplicates pile up, buckets fill.
  logic [15:0] key_pool [POOL_SIZE];

  // Per-phase traffic shape. Phases 0, 1, 3 and 5 lean toward inserts to fill
  // buckets, phases 2 and 4 toward deletes to drain them again.
  int phase_send_idle [PHASE_COUNT] = '{0, 70, 0, 22, 0, 22};
  int phase_recv_stall [PHASE_COUNT] = '{0, 0, 70, 22, 0, 22};
  int phase_insert_pct [PHASE_COUNT] = '{55, 40, 35, 45, 30, 50};
  int phase_delete_pct [PHASE_COUNT] = '{20, 35, 40, 30, 45, 25};

  block_hash_queue_table_top #(
    .NUM_BUCKETS(NUM_BUCKETS),
    .ENTRIES_PER_BUCKET(ENTRIES_PER_BUCKET),
    .BLOCK_BITS(BLOCK_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  hash_table_checker #(
    .NUM_BUCKETS(NUM_BUCKETS),
    .ENTRIES_PER_BUCKET(ENTRIES_PER_BUCKET),
    .BLOCK_BITS(BLOCK_BITS)
  ) checker_i (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp),
    .mismatches(mismatches),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Response side: a requested hold-off wins, otherwise stall at the phase's rate.
  always @(posedge clk) begin
    if (hold_orders != hold_taken) begin
      hold_taken <= hold_orders;
      hold_left <= HOLD_CYCLES;
      rsp_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: counts cycles in which no beat is accepted on either channel.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one request beat, after random idle cycles, and holds it until taken.
  // This task lowers valid only in idle cycles, so back-to-back beats keep it high.
  task automatic send_beat(input bqt_pkg::req_t beat);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req <= beat;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  // Stops offering requests until every response the checker awaits has arrived.
  // The wait runs on the falling edge so the checker has seen the last beats.
  task automatic wait_responses_done();
    req_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  // One random request: mostly pool keys so that hits, duplicates and full
  // buckets happen often, a few fully random keys, and now and then the no-op code.
  function automatic bqt_pkg::req_t random_request(input int insert_pct, input int delete_pct);
    bqt_pkg::req_t beat;
    int            roll;
    roll = $urandom_range(99);
    if (roll < 3) beat.action = ACT_UNUSED;
    else if (roll < 3 + insert_pct) beat.action = bqt_pkg::ACT_INSERT;
    else if (roll < 3 + insert_pct + delete_pct) beat.action = bqt_pkg::ACT_DELETE;
    else beat.action = bqt_pkg::ACT_SEARCH;
    if ($urandom_range(99) < 85) beat.block_number = key_pool[$urandom_range(POOL_SIZE - 1)];
    else beat.block_number = 16'($urandom);
    return beat;
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part. The block holds its input stalled while it clears the
    // bucket counts after reset; send_beat simply waits that out.
    send_beat(bqt_pkg::req_t'{bqt_pkg::ACT_SEARCH, 16'h0000}); // search of an empty table misses
    send_beat(bqt_pkg::req_t'{bqt_pkg::ACT_DELETE, 16'hFFFF}); // delete of an absent key misses
    send_beat(bqt_pkg::req_t'{ACT_UNUSED, 16'hFFFF});   // unused action answers all zero
    send_beat(bqt_pkg::req_t'{bqt_pkg::ACT_INSERT, 16'h0000});
    send_beat(bqt_pkg::req_t'{bqt_pkg::ACT_INSERT, 16'hFFFF});
    send_beat(bqt_pkg::req_t'{bqt_pkg::ACT_SEARCH, 16'h0000});
    send_beat(bqt_pkg::req_t'{bqt_pkg::ACT_SEARCH, 16'hFFFF});
    // Fill bucket one to the brim, with a duplicate in slots one and two.
    send_beat(bqt_pkg::req_t'{bqt_pkg::ACT_INSERT, 16'h0001});
    send_beat(bqt_pkg::req_t'{bqt_pkg::ACT_INSERT, 16'h0005});
    send_beat(bqt_pkg::req_t'{bqt_pkg::ACT_INSERT, 16'h0005});
    send_beat(bqt_pkg::req_t'{bqt_pkg::ACT_INSERT, 16'h0009});
    send_beat(bqt_pkg::req_t'{bqt_pkg::ACT_INSERT, 16'h000D});
    send_beat(bqt_pkg::req_t'{bqt_pkg::ACT_INSERT, 16'h0011});
    send_beat(bqt_pkg::req_t'{bqt_pkg::ACT_INSERT, 16'h0015});
    send_beat(bqt_pkg::req_t'{bqt_pkg::ACT_INSERT, 16'h0019}); // last free slot, position seven
    send_beat(bqt_pkg::req_t'{bqt_pkg::ACT_INSERT, 16'h8001}); // bucket full: nothing is stored
    // Search reports the first of the duplicates.
    send_beat(bqt_pkg::req_t'{bqt_pkg::ACT_SEARCH, 16'h0005});
    send_beat(bqt_pkg::req_t'{bqt_pkg::ACT_DELETE, 16'h0005}); // delete removes only the first
    // The second copy has moved down a slot.
    send_beat(bqt_pkg::req_t'{bqt_pkg::ACT_SEARCH, 16'h0005});
    send_beat(bqt_pkg::req_t'{bqt_pkg::ACT_DELETE, 16'h0001}); // delete at the head of the bucket
    send_beat(bqt_pkg::req_t'{bqt_pkg::ACT_DELETE, 16'h0019}); // delete at the tail of the bucket
    send_beat(bqt_pkg::req_t'{bqt_pkg::ACT_DELETE, 16'hFFFF});
    send_beat(bqt_pkg::req_t'{bqt_pkg::ACT_DELETE, 16'h0000});
    send_beat(bqt_pkg::req_t'{ACT_UNUSED, 16'h0000});
    wait_responses_done();

    // Random part, one phase per idling pattern.
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      send_idle_pct = phase_send_idle[phase];
      recv_stall_pct = phase_recv_stall[phase];
      for (int i = 0; i < POOL_SIZE; i++) begin
        key_pool[i] = 16'($urandom);
        key_pool[i][1:0] = 2'(i);
      end
      for (int n = 0; n < BEATS_PER_PHASE; n++) begin
        // In two phases the receiver holds off for a long stretch while requests
        // keep coming, so the response register fills and the input stalls.
        if (n == 60 && (phase == 0 || phase == 3)) hold_orders++;
        send_beat(random_request(phase_insert_pct[phase], phase_delete_pct[phase]));
      end
      // Let every response come back before the traffic shape changes.
      wait_responses_done();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
